// ----- rtl/grb_pkg.sv -----
package grb_pkg;

    // Width of a server load and of a reported maximum
    localparam int unsigned LOAD_W = 40;
    localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};

    // Input operations, carried in s_tuser
    typedef enum logic [1:0] {
        OP_LOAD_JOB   = 2'd0,
        OP_LOAD_TOTAL = 2'd1,
        OP_RUN        = 2'd2,
        OP_READ       = 2'd3
    } op_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MODE            = 2'd0,
        CFG_SERVER_COUNT    = 2'd1,
        CFG_SERVER_CAPACITY = 2'd2
    } cfg_index_t;

    // Placement modes; code three behaves as adaptive
    localparam logic [1:0] MODE_KEEP   = 2'd0;
    localparam logic [1:0] MODE_GREEDY = 2'd1;

    // Result kinds, carried in m_tuser
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_ASSIGN = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD_OUT,
        ST_RUN_START,
        ST_SORT_INIT,
        ST_SORT_HOLD,
        ST_SORT_STEP,
        ST_SORT_ORD,
        ST_SORT_CMP,
        ST_G_ORD,
        ST_G_JOB,
        ST_G_DATA,
        ST_G_SCAN,
        ST_G_PUT,
        ST_K_RD,
        ST_K_DATA,
        ST_K_PUT,
        ST_MAX_SCAN,
        ST_MAX_MUL,
        ST_MAX_CMP,
        ST_STATUS
    } state_t;

    // Address source for the job stores' read port
    typedef enum logic [1:0] {
        JA_RP,
        JA_CNT,
        JA_ORD
    } job_addr_t;

    // Server chosen by a placement step
    typedef enum logic [1:0] {
        PUT_K,
        PUT_BEST,
        PUT_ORIGIN
    } put_sel_t;

    typedef struct packed {
        logic      load_job;
        logic      load_total;
        job_addr_t job_addr;
        logic      ord_rd_prev;
        logic      ord_we;
        logic      ord_wsel_i;
        logic      latch_t;
        logic      latch_j_ord;
        logic      latch_j_cnt;
        logic      latch_prev;
        logic      clr_run;
        logic      clr_loads;
        logic      put;
        put_sel_t  put_sel;
        logic      scan_init;
        logic      scan_step;
        logic      max_init;
        logic      max_step;
        logic      mul;
        logic      acc_from_fail;
        logic      acc_from_cmp;
        logic      out_status;
        logic      out_assign;
    } cmd_t;

    typedef struct packed {
        logic rd_ok;
        logic out_free;
        logic t_less;
        logic cmp_ok;
    } sts_t;

    // Servers in use: zero acts as one, large values clip to the store size
    function automatic logic [6:0] used_servers(input logic [4:0] sc,
                                                input logic [6:0] max_srv);
        logic [6:0] r;
        r = {2'b00, sc};
        if (sc == 5'd0) begin
            r = 7'd1;
        end else if ({2'b00, sc} > max_srv) begin
            r = max_srv;
        end
        return r;
    endfunction

endpackage

// ----- rtl/grb_datapath.sv -----
module grb_datapath #(
    parameter int MAX_JOBS    = 256,
    parameter int MAX_SERVERS = 16,
    parameter int TW          = 32,
    parameter int JW          = 8,
    parameter int JCW         = 9,
    parameter int SW          = 4,
    parameter int SCW         = 5
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  grb_pkg::cmd_t               cmd,
    output grb_pkg::sts_t               sts,
    input  logic [JCW-1:0]              cnt_i,
    input  logic [JCW-1:0]              cnt_k,
    input  logic [SW-1:0]               cnt_s,
    input  logic [SCW-1:0]              n_srv,
    input  logic [8:0]                  capacity,
    input  logic [15:0]                 job_id,
    input  logic [31:0]                 job_time,
    input  logic [3:0]                  server,
    input  logic [grb_pkg::LOAD_W-1:0]  server_total,
    output logic [JCW-1:0]              job_count,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [71:0]                 m_tdata,
    output logic [0:0]                  m_tuser,
    output logic                        m_tlast
);

    localparam int LW    = grb_pkg::LOAD_W;
    localparam int SUM_W = LW + 1;
    localparam int PW    = LW + 5;
    localparam int XW    = (SW > 4) ? SW : 4;
    localparam logic [7:0]     MAXS8 = 8'(MAX_SERVERS);
    localparam logic [JCW-1:0] JFULL = JCW'(MAX_JOBS);

    logic [15:0]   ids_mem   [MAX_JOBS];
    logic [TW-1:0] times_mem [MAX_JOBS];
    logic [3:0]    orig_mem  [MAX_JOBS];
    logic [SW-1:0] asg_mem   [MAX_JOBS];
    logic [JW-1:0] ord_mem   [MAX_JOBS];

    logic [15:0]   ids_rd_reg;
    logic [TW-1:0] times_rd_reg;
    logic [3:0]    orig_rd_reg;
    logic [SW-1:0] asg_rd_reg;
    logic [JW-1:0] ord_rd_reg;

    logic [JCW-1:0] jc_reg;
    logic [JCW-1:0] rp_reg;
    logic           ovf_reg;
    logic           run_done_reg;
    logic           acc_reg;
    logic           fail_reg;
    logic           found_reg;
    logic           m_valid_reg;

    logic [LW-1:0]  loads_reg      [MAX_SERVERS];
    logic [JCW-1:0] cnt_reg        [MAX_SERVERS];
    logic [LW-1:0]  orig_loads_reg [MAX_SERVERS];

    logic [TW-1:0]  t_reg;
    logic [3:0]     orig_reg;
    logic [JW-1:0]  j_reg;
    logic [JW-1:0]  prev_reg;
    logic [SW-1:0]  best_reg;
    logic [LW-1:0]  best_load_reg;
    logic [LW-1:0]  nm_reg;
    logic [LW-1:0]  om_reg;
    logic [PW-1:0]  p20_reg;
    logic [PW-1:0]  p19_reg;

    logic           o_kind_reg;
    logic [15:0]    o_id_reg;
    logic [3:0]     o_new_reg;
    logic [3:0]     o_old_reg;
    logic           o_moved_reg;
    logic           o_reb_reg;
    logic [LW-1:0]  o_max_reg;
    logic           o_err_reg;
    logic           o_last_reg;

    logic [JW-1:0]    job_raddr;
    logic [JW-1:0]    ord_raddr;
    logic [JW-1:0]    ord_wdata;
    logic             job_wr;
    logic [SW-1:0]    clamp_s;
    logic [SW-1:0]    target;
    logic [SUM_W-1:0] sum;
    logic [LW-1:0]    sum_sat;
    logic [LW-1:0]    ld_s;
    logic             elig;
    logic             better;
    logic [XW-1:0]    asg_x;
    logic [XW-1:0]    orig_x;
    logic             rd_last;

    assign job_wr = cmd.load_job && (jc_reg != JFULL);

    always_comb begin
        case (cmd.job_addr)
            grb_pkg::JA_CNT: job_raddr = cnt_i[JW-1:0];
            grb_pkg::JA_ORD: job_raddr = ord_rd_reg;
            default:         job_raddr = rp_reg[JW-1:0];
        endcase
    end

    assign ord_raddr = cmd.ord_rd_prev ? JW'(cnt_k - 1'b1) : cnt_k[JW-1:0];
    assign ord_wdata = cmd.ord_wsel_i ? cnt_i[JW-1:0] : prev_reg;

    // Origin beyond the servers in use falls on the highest one
    assign clamp_s = (8'(orig_reg) < 8'(n_srv)) ? SW'(orig_reg) : SW'(n_srv - 1'b1);

    always_comb begin
        case (cmd.put_sel)
            grb_pkg::PUT_K:    target = SW'(cnt_k);
            grb_pkg::PUT_BEST: target = found_reg ? best_reg : clamp_s;
            default:           target = clamp_s;
        endcase
    end

    assign sum     = {1'b0, loads_reg[target]} + SUM_W'(t_reg);
    assign sum_sat = sum[LW] ? grb_pkg::LOAD_MAX : sum[LW-1:0];

    assign ld_s   = loads_reg[cnt_s];
    assign elig   = 16'(cnt_reg[cnt_s]) < 16'(capacity);
    assign better = !found_reg || (ld_s < best_load_reg);

    assign asg_x   = XW'(asg_rd_reg);
    assign orig_x  = XW'(orig_rd_reg);
    assign rd_last = (rp_reg + 1'b1) == jc_reg;

    // Job stores
    always_ff @(posedge aclk) begin
        if (job_wr) begin
            ids_mem[jc_reg[JW-1:0]]   <= job_id;
            times_mem[jc_reg[JW-1:0]] <= job_time[TW-1:0];
            orig_mem[jc_reg[JW-1:0]]  <= server;
        end
        ids_rd_reg   <= ids_mem[job_raddr];
        times_rd_reg <= times_mem[job_raddr];
        orig_rd_reg  <= orig_mem[job_raddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.put) begin
            asg_mem[j_reg] <= target;
        end
        asg_rd_reg <= asg_mem[job_raddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.ord_we) begin
            ord_mem[cnt_k[JW-1:0]] <= ord_wdata;
        end
        ord_rd_reg <= ord_mem[ord_raddr];
    end

    // Server loads, job counts and loaded totals
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < MAX_SERVERS; s++) begin
                loads_reg[s]      <= '0;
                cnt_reg[s]        <= '0;
                orig_loads_reg[s] <= '0;
            end
        end else begin
            if (cmd.clr_loads) begin
                for (int s = 0; s < MAX_SERVERS; s++) begin
                    loads_reg[s] <= '0;
                    cnt_reg[s]   <= '0;
                end
            end else if (cmd.put) begin
                loads_reg[target] <= sum_sat;
                cnt_reg[target]   <= cnt_reg[target] + 1'b1;
            end
            if (cmd.load_total && (8'(server) < MAXS8)) begin
                orig_loads_reg[SW'(server)] <= server_total;
            end
        end
    end

    // Run control flags and batch bookkeeping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            jc_reg       <= '0;
            rp_reg       <= '0;
            ovf_reg      <= 1'b0;
            run_done_reg <= 1'b0;
            acc_reg      <= 1'b0;
            fail_reg     <= 1'b0;
            found_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.load_job) begin
                if (job_wr) begin
                    jc_reg <= jc_reg + 1'b1;
                end else begin
                    ovf_reg <= 1'b1;
                end
                run_done_reg <= 1'b0;
                rp_reg       <= '0;
            end
            if (cmd.clr_run) begin
                acc_reg  <= 1'b0;
                fail_reg <= 1'b0;
            end
            if (cmd.put && (cmd.put_sel == grb_pkg::PUT_BEST) && !found_reg) begin
                fail_reg <= 1'b1;
            end
            if (cmd.scan_init) begin
                found_reg <= 1'b0;
            end else if (cmd.scan_step && elig && better) begin
                found_reg <= 1'b1;
            end
            if (cmd.acc_from_fail) begin
                acc_reg <= !fail_reg;
            end
            if (cmd.acc_from_cmp) begin
                acc_reg <= sts.cmp_ok;
            end
            if (cmd.out_status) begin
                run_done_reg <= 1'b1;
                rp_reg       <= '0;
            end
            if (cmd.out_assign) begin
                if (rd_last) begin
                    jc_reg       <= '0;
                    rp_reg       <= '0;
                    ovf_reg      <= 1'b0;
                    run_done_reg <= 1'b0;
                end else begin
                    rp_reg <= rp_reg + 1'b1;
                end
            end
            if (cmd.out_status || cmd.out_assign) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        if (cmd.latch_t) begin
            t_reg    <= times_rd_reg;
            orig_reg <= orig_rd_reg;
        end
        if (cmd.latch_j_ord) begin
            j_reg <= ord_rd_reg;
        end else if (cmd.latch_j_cnt) begin
            j_reg <= cnt_i[JW-1:0];
        end
        if (cmd.latch_prev) begin
            prev_reg <= ord_rd_reg;
        end
        if (cmd.scan_step && elig && better) begin
            best_reg      <= cnt_s;
            best_load_reg <= ld_s;
        end
        if (cmd.max_init) begin
            nm_reg <= '0;
            om_reg <= '0;
        end else if (cmd.max_step) begin
            if (loads_reg[cnt_s] > nm_reg) begin
                nm_reg <= loads_reg[cnt_s];
            end
            if (orig_loads_reg[cnt_s] > om_reg) begin
                om_reg <= orig_loads_reg[cnt_s];
            end
        end
        if (cmd.mul) begin
            p20_reg <= PW'({nm_reg, 4'b0}) + PW'({nm_reg, 2'b0});
            p19_reg <= PW'({om_reg, 4'b0}) + PW'({om_reg, 1'b0}) + PW'(om_reg);
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.out_status) begin
            o_kind_reg  <= grb_pkg::KIND_STATUS;
            o_id_reg    <= '0;
            o_new_reg   <= '0;
            o_old_reg   <= '0;
            o_moved_reg <= 1'b0;
            o_reb_reg   <= acc_reg;
            o_max_reg   <= nm_reg;
            o_err_reg   <= fail_reg || ovf_reg;
            o_last_reg  <= 1'b0;
        end else if (cmd.out_assign) begin
            o_kind_reg  <= grb_pkg::KIND_ASSIGN;
            o_id_reg    <= ids_rd_reg;
            o_new_reg   <= asg_x[3:0];
            o_old_reg   <= orig_rd_reg;
            o_moved_reg <= asg_x != orig_x;
            o_reb_reg   <= acc_reg;
            o_max_reg   <= '0;
            o_err_reg   <= 1'b0;
            o_last_reg  <= rd_last;
        end
    end

    assign sts.rd_ok    = run_done_reg && (rp_reg < jc_reg);
    assign sts.out_free = !m_valid_reg || m_tready;
    assign sts.t_less   = times_rd_reg < t_reg;
    assign sts.cmp_ok   = !fail_reg && (p20_reg < p19_reg);

    assign job_count = jc_reg;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {5'b0, o_err_reg, o_max_reg, o_reb_reg, o_moved_reg,
                        o_old_reg, o_new_reg, o_id_reg};
    assign m_tuser   = o_kind_reg;
    assign m_tlast   = o_last_reg;

endmodule

// ----- rtl/grb_ctrl.sv -----
module grb_ctrl #(
    parameter int JCW = 9,
    parameter int SW  = 4,
    parameter int SCW = 5
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    input  logic [1:0]      operation,
    output logic            s_tready,
    input  logic [1:0]      mode,
    input  logic [SCW-1:0]  n_srv,
    input  logic [JCW-1:0]  job_count,
    input  grb_pkg::sts_t   sts,
    output grb_pkg::cmd_t   cmd,
    output logic [JCW-1:0]  cnt_i,
    output logic [JCW-1:0]  cnt_k,
    output logic [SW-1:0]   cnt_s
);

    grb_pkg::state_t state_reg, state_next;
    grb_pkg::op_t    op;

    logic [JCW-1:0] i_reg, i_next;
    logic [JCW-1:0] k_reg, k_next;
    logic [SW-1:0]  s_reg, s_next;
    logic           fb_reg, fb_next;

    logic i_end, k_end, k_zero, k_lt_n, s_last, mode_keep, mode_greedy;

    assign op          = grb_pkg::op_t'(operation);
    assign i_end       = i_reg == job_count;
    assign k_end       = k_reg == job_count;
    assign k_zero      = k_reg == '0;
    assign k_lt_n      = 16'(k_reg) < 16'(n_srv);
    assign s_last      = SCW'(s_reg) == (n_srv - 1'b1);
    assign mode_keep   = mode == grb_pkg::MODE_KEEP;
    assign mode_greedy = mode == grb_pkg::MODE_GREEDY;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= grb_pkg::ST_IDLE;
            i_reg     <= '0;
            k_reg     <= '0;
            s_reg     <= '0;
            fb_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
            s_reg     <= s_next;
            fb_reg    <= fb_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            grb_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (op) inside
                        grb_pkg::OP_LOAD_JOB, grb_pkg::OP_LOAD_TOTAL: state_next = grb_pkg::ST_IDLE;
                        grb_pkg::OP_RUN:  state_next = grb_pkg::ST_RUN_START;
                        grb_pkg::OP_READ: begin
                            if (sts.rd_ok) state_next = grb_pkg::ST_RD_OUT;
                        end
                        default: state_next = grb_pkg::ST_IDLE;
                    endcase
                end
            end
            grb_pkg::ST_RD_OUT: if (sts.out_free) state_next = grb_pkg::ST_IDLE;
            grb_pkg::ST_RUN_START:
                state_next = mode_keep ? grb_pkg::ST_K_RD : grb_pkg::ST_SORT_INIT;
            grb_pkg::ST_SORT_INIT:
                state_next = i_end ? grb_pkg::ST_G_ORD : grb_pkg::ST_SORT_HOLD;
            grb_pkg::ST_SORT_HOLD: state_next = grb_pkg::ST_SORT_STEP;
            grb_pkg::ST_SORT_STEP:
                state_next = k_zero ? grb_pkg::ST_SORT_INIT : grb_pkg::ST_SORT_ORD;
            grb_pkg::ST_SORT_ORD: state_next = grb_pkg::ST_SORT_CMP;
            grb_pkg::ST_SORT_CMP:
                state_next = sts.t_less ? grb_pkg::ST_SORT_STEP : grb_pkg::ST_SORT_INIT;
            grb_pkg::ST_G_ORD:
                state_next = k_end ? grb_pkg::ST_MAX_SCAN : grb_pkg::ST_G_JOB;
            grb_pkg::ST_G_JOB: state_next = grb_pkg::ST_G_DATA;
            grb_pkg::ST_G_DATA:
                state_next = k_lt_n ? grb_pkg::ST_G_PUT : grb_pkg::ST_G_SCAN;
            grb_pkg::ST_G_SCAN: if (s_last) state_next = grb_pkg::ST_G_PUT;
            grb_pkg::ST_G_PUT: state_next = grb_pkg::ST_G_ORD;
            grb_pkg::ST_K_RD:
                state_next = i_end ? grb_pkg::ST_MAX_SCAN : grb_pkg::ST_K_DATA;
            grb_pkg::ST_K_DATA: state_next = grb_pkg::ST_K_PUT;
            grb_pkg::ST_K_PUT: state_next = grb_pkg::ST_K_RD;
            grb_pkg::ST_MAX_SCAN: begin
                if (s_last) begin
                    if (fb_reg || mode_greedy) state_next = grb_pkg::ST_STATUS;
                    else                       state_next = grb_pkg::ST_MAX_MUL;
                end
            end
            grb_pkg::ST_MAX_MUL: state_next = grb_pkg::ST_MAX_CMP;
            grb_pkg::ST_MAX_CMP:
                state_next = sts.cmp_ok ? grb_pkg::ST_STATUS : grb_pkg::ST_K_RD;
            grb_pkg::ST_STATUS: if (sts.out_free) state_next = grb_pkg::ST_IDLE;
            default: state_next = grb_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.job_addr = grb_pkg::JA_RP;
        cmd.put_sel  = grb_pkg::PUT_ORIGIN;
        s_tready     = 1'b0;
        unique case (state_reg)
            grb_pkg::ST_IDLE: begin
                s_tready       = 1'b1;
                cmd.load_job   = s_tvalid && (op == grb_pkg::OP_LOAD_JOB);
                cmd.load_total = s_tvalid && (op == grb_pkg::OP_LOAD_TOTAL);
            end
            grb_pkg::ST_RD_OUT: cmd.out_assign = sts.out_free;
            grb_pkg::ST_RUN_START: begin
                cmd.clr_run   = 1'b1;
                cmd.clr_loads = 1'b1;
            end
            grb_pkg::ST_SORT_INIT: cmd.job_addr = grb_pkg::JA_CNT;
            grb_pkg::ST_SORT_HOLD: cmd.latch_t = 1'b1;
            grb_pkg::ST_SORT_STEP: begin
                cmd.ord_we      = k_zero;
                cmd.ord_wsel_i  = 1'b1;
                cmd.ord_rd_prev = !k_zero;
            end
            grb_pkg::ST_SORT_ORD: begin
                cmd.latch_prev = 1'b1;
                cmd.job_addr   = grb_pkg::JA_ORD;
            end
            grb_pkg::ST_SORT_CMP: begin
                cmd.ord_we     = 1'b1;
                cmd.ord_wsel_i = !sts.t_less;
            end
            grb_pkg::ST_G_ORD: cmd.max_init = k_end;
            grb_pkg::ST_G_JOB: begin
                cmd.latch_j_ord = 1'b1;
                cmd.job_addr    = grb_pkg::JA_ORD;
            end
            grb_pkg::ST_G_DATA: begin
                cmd.latch_t   = 1'b1;
                cmd.scan_init = !k_lt_n;
            end
            grb_pkg::ST_G_SCAN: cmd.scan_step = 1'b1;
            grb_pkg::ST_G_PUT: begin
                cmd.put     = 1'b1;
                cmd.put_sel = k_lt_n ? grb_pkg::PUT_K : grb_pkg::PUT_BEST;
            end
            grb_pkg::ST_K_RD: begin
                cmd.job_addr = grb_pkg::JA_CNT;
                cmd.max_init = i_end;
            end
            grb_pkg::ST_K_DATA: begin
                cmd.latch_t     = 1'b1;
                cmd.latch_j_cnt = 1'b1;
            end
            grb_pkg::ST_K_PUT: cmd.put = 1'b1;
            grb_pkg::ST_MAX_SCAN: begin
                cmd.max_step      = 1'b1;
                cmd.acc_from_fail = s_last && !fb_reg && mode_greedy;
            end
            grb_pkg::ST_MAX_MUL: cmd.mul = 1'b1;
            grb_pkg::ST_MAX_CMP: begin
                cmd.acc_from_cmp = 1'b1;
                cmd.clr_loads    = !sts.cmp_ok;
            end
            grb_pkg::ST_STATUS: cmd.out_status = sts.out_free;
            default: ;
        endcase
    end

    always_comb begin
        i_next  = i_reg;
        k_next  = k_reg;
        s_next  = s_reg;
        fb_next = fb_reg;
        case (state_reg)
            grb_pkg::ST_RUN_START: begin
                i_next  = '0;
                k_next  = '0;
                fb_next = mode_keep;
            end
            grb_pkg::ST_SORT_INIT: k_next = i_end ? '0 : i_reg;
            grb_pkg::ST_SORT_STEP: if (k_zero) i_next = i_reg + 1'b1;
            grb_pkg::ST_SORT_CMP: begin
                if (sts.t_less) k_next = k_reg - 1'b1;
                else            i_next = i_reg + 1'b1;
            end
            grb_pkg::ST_G_ORD:  if (k_end) s_next = '0;
            grb_pkg::ST_G_DATA: s_next = '0;
            grb_pkg::ST_G_SCAN: if (!s_last) s_next = s_reg + 1'b1;
            grb_pkg::ST_G_PUT:  k_next = k_reg + 1'b1;
            grb_pkg::ST_K_RD:   if (i_end) s_next = '0;
            grb_pkg::ST_K_PUT:  i_next = i_reg + 1'b1;
            grb_pkg::ST_MAX_SCAN: if (!s_last) s_next = s_reg + 1'b1;
            grb_pkg::ST_MAX_CMP: begin
                if (!sts.cmp_ok) begin
                    fb_next = 1'b1;
                    i_next  = '0;
                end
            end
            default: ;
        endcase
    end

    assign cnt_i = i_reg;
    assign cnt_k = k_reg;
    assign cnt_s = s_reg;

endmodule

// ----- rtl/greedy_job_rebalancer_unit.sv -----
// Greedy job rebalancer: longest-processing-time-first placement of jobs on servers.
// Input channel (s_*): one transaction per command, opcode in s_tuser. Load-job and
// load-total transactions are taken one per cycle while idle and give no result. A run
// transaction computes the placement and returns one status transaction; read
// transactions then return the assignments one per read, in load order, the last
// flagged by m_tlast, after which the job table empties for the next batch.
// Configuration: cfg_wr_en/cfg_index/cfg_wr_data write mode, server count or
// capacity, one register per write; write them only while the block is idle.
// Sequence: a read passes the job store read, then the result register. A run of J
// jobs on N servers is paced by the job and order stores, each with one read port:
// the insertion sort steps through each job and each shifted entry (up to J*J/2
// shifts), greedy placement handles each job and scans the N servers for each job
// past the first N, the keep pass visits each job, and the final maximum scans the
// N servers; an adaptive fallback adds one more keep pass and scan.
// Reset: synchronous, active low; clears loads, totals, the job count and the
// flags, and sets the registers to adaptive, 16 servers, capacity 256.
// Stall: the result sits in an output register; while m_tready is low the block
// holds it and finishes its work; one more run or read is taken, then waits.
module greedy_job_rebalancer_unit #(
    parameter int MAX_JOBS    = 256,
    parameter int MAX_SERVERS = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // job_id[15:0], job_time[47:16], server[51:48], server_total[91:52], zero pad
    input  logic [95:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_job_id[15:0], new_server[19:16], old_server[23:20], moved[24],
    // rebalanced[25], max_load[65:26], error[66], zero pad
    output logic [71:0] m_tdata,
    // kind[0]
    output logic [0:0]  m_tuser,
    output logic        m_tlast
);

    localparam int JW  = $clog2(MAX_JOBS);
    localparam int JCW = $clog2(MAX_JOBS + 1);
    localparam int SW  = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int SCW = $clog2(MAX_SERVERS + 1);
    localparam int TW  = (TIME_BITS < 32) ? TIME_BITS : 32;

    logic [1:0] mode_reg;
    logic [4:0] srv_count_reg;
    logic [8:0] capacity_reg;

    logic [SCW-1:0] n_srv;
    logic [JCW-1:0] job_count;
    logic [JCW-1:0] cnt_i;
    logic [JCW-1:0] cnt_k;
    logic [SW-1:0]  cnt_s;

    grb_pkg::cmd_t cmd;
    grb_pkg::sts_t sts;

    // Configuration registers; an index past the list is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= 2'd2;
            srv_count_reg <= 5'd16;
            capacity_reg  <= 9'd256;
        end else if (cfg_wr_en) begin
            unique case (grb_pkg::cfg_index_t'(cfg_index))
                grb_pkg::CFG_MODE:            mode_reg      <= cfg_wr_data[1:0];
                grb_pkg::CFG_SERVER_COUNT:    srv_count_reg <= cfg_wr_data[4:0];
                grb_pkg::CFG_SERVER_CAPACITY: capacity_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Servers in use, clipped to the range the loads store holds
    assign n_srv = SCW'(grb_pkg::used_servers(srv_count_reg, 7'(MAX_SERVERS)));

    grb_ctrl #(
        .JCW (JCW),
        .SW  (SW),
        .SCW (SCW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .operation (s_tuser),
        .s_tready  (s_tready),
        .mode      (mode_reg),
        .n_srv     (n_srv),
        .job_count (job_count),
        .sts       (sts),
        .cmd       (cmd),
        .cnt_i     (cnt_i),
        .cnt_k     (cnt_k),
        .cnt_s     (cnt_s)
    );

    grb_datapath #(
        .MAX_JOBS    (MAX_JOBS),
        .MAX_SERVERS (MAX_SERVERS),
        .TW          (TW),
        .JW          (JW),
        .JCW         (JCW),
        .SW          (SW),
        .SCW         (SCW)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .cnt_i        (cnt_i),
        .cnt_k        (cnt_k),
        .cnt_s        (cnt_s),
        .n_srv        (n_srv),
        .capacity     (capacity_reg),
        .job_id       (s_tdata[15:0]),
        .job_time     (s_tdata[47:16]),
        .server       (s_tdata[51:48]),
        .server_total (s_tdata[91:52]),
        .job_count    (job_count),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

`ifndef NO_ASSERTIONS
    // A run transaction hands control to the sequencer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == grb_pkg::OP_RUN)) |=> !s_tready)
        else $error("run transaction did not start the sequencer");

    // A job load transaction never blocks the next one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == grb_pkg::OP_LOAD_JOB)) |=> s_tready)
        else $error("job load stalled the input");

    // A status transaction is never the end of a readout
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[0] == grb_pkg::KIND_STATUS)) |-> !m_tlast)
        else $error("status transaction flagged as last");

    // Assignments carry no load maximum and no error
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[0] == grb_pkg::KIND_ASSIGN)) |->
            ((m_tdata[65:26] == '0) && !m_tdata[66]))
        else $error("assignment carries status fields");
`endif

endmodule

// ----- tb/greedy_job_rebalancer_unit_tb.sv -----
module greedy_job_rebalancer_unit_tb;
    import grb_pkg::*;

    localparam int JOB_DEPTH   = 256;
    localparam int SRV_DEPTH   = 16;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int SETTLE      = 40;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [8:0]  cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    greedy_job_rebalancer_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    // One result as the block should present it
    typedef struct {
        logic        kind;
        logic [15:0] job_id;
        logic [3:0]  new_srv;
        logic [3:0]  old_srv;
        logic        moved;
        logic        rebal;
        logic [39:0] max_load;
        logic        err;
        logic        last;
    } placement_t;

    placement_t pending_results[$];

    // Shadow of the block's registers and stores
    logic [1:0]  sh_mode;
    logic [4:0]  sh_count;
    logic [8:0]  sh_cap;
    logic [15:0] sh_ids[JOB_DEPTH];
    logic [31:0] sh_times[JOB_DEPTH];
    logic [3:0]  sh_orig[JOB_DEPTH];
    int          sh_order[JOB_DEPTH];
    logic [3:0]  sh_asg[JOB_DEPTH];
    logic [39:0] sh_load[SRV_DEPTH];
    int          sh_held[SRV_DEPTH];
    logic [39:0] sh_total[SRV_DEPTH];
    int          sh_jobs;
    int          sh_rp;
    bit          sh_ovf, sh_done, sh_acc;

    int fails = 0;
    int cycles = 0;
    int items_sent = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL greedy_job_rebalancer_unit");
            $finish;
        end
    end

    function automatic int servers_in_use();
        if (sh_count == 0) return 1;
        if (sh_count > SRV_DEPTH) return SRV_DEPTH;
        return sh_count;
    endfunction

    function automatic int clipped_origin(int j, int n);
        return (sh_orig[j] < n) ? int'(sh_orig[j]) : n - 1;
    endfunction

    function automatic void clear_loads();
        for (int s = 0; s < SRV_DEPTH; s++) begin
            sh_load[s] = '0;
            sh_held[s] = 0;
        end
    endfunction

    // Add a job to a server, saturating the total
    function automatic void assign_job(int j, int s);
        logic [40:0] sum;
        sum = {1'b0, sh_load[s]} + {9'd0, sh_times[j]};
        sh_asg[j] = s[3:0];
        sh_load[s] = sum[40] ? LOAD_MAX : sum[39:0];
        sh_held[s]++;
    endfunction

    function automatic void keep_pass(int n);
        clear_loads();
        for (int j = 0; j < sh_jobs; j++) assign_job(j, clipped_origin(j, n));
    endfunction

    function automatic logic [39:0] peak(bit of_totals, int n);
        logic [39:0] m;
        m = '0;
        for (int s = 0; s < n; s++) begin
            if (of_totals && sh_total[s] > m) m = sh_total[s];
            if (!of_totals && sh_load[s] > m) m = sh_load[s];
        end
        return m;
    endfunction

    // Longest time first; returns 1 when some job found no room
    function automatic bit lpt_pass(int n);
        bit fail;
        int k, j, best;
        bit found;
        fail = 0;
        for (int i = 0; i < sh_jobs; i++) begin
            k = i;
            while (k > 0 && sh_times[sh_order[k-1]] < sh_times[i]) begin
                sh_order[k] = sh_order[k-1];
                k--;
            end
            sh_order[k] = i;
        end
        clear_loads();
        for (k = 0; k < sh_jobs; k++) begin
            j = sh_order[k];
            if (k < n) begin
                assign_job(j, k);
            end else begin
                found = 0;
                best = 0;
                for (int s = 0; s < n; s++) begin
                    if (sh_held[s] < sh_cap && (!found || sh_load[s] < sh_load[best])) begin
                        best = s;
                        found = 1;
                    end
                end
                if (!found) begin
                    fail = 1;
                    best = clipped_origin(j, n);
                end
                assign_job(j, best);
            end
        end
        return fail;
    endfunction

    function automatic void shadow_reset();
        sh_mode = 2'd2;
        sh_count = 5'd16;
        sh_cap = 9'd256;
        clear_loads();
        for (int s = 0; s < SRV_DEPTH; s++) sh_total[s] = '0;
        sh_jobs = 0;
        sh_rp = 0;
        sh_ovf = 0;
        sh_done = 0;
        sh_acc = 0;
    endfunction

    // Work out what one accepted transaction should produce
    function automatic void predict_placement(op_t op, logic [15:0] id, logic [31:0] t,
                                              logic [3:0] srv, logic [39:0] total);
        placement_t r;
        int n;
        bit fail;
        n = servers_in_use();
        r = '{default: '0};
        case (op)
            OP_LOAD_JOB: begin
                if (sh_jobs < JOB_DEPTH) begin
                    sh_ids[sh_jobs] = id;
                    sh_times[sh_jobs] = t;
                    sh_orig[sh_jobs] = srv;
                    sh_jobs++;
                end else begin
                    sh_ovf = 1;
                end
                sh_done = 0;
                sh_rp = 0;
            end
            OP_LOAD_TOTAL: begin
                sh_total[srv] = total;
            end
            OP_RUN: begin
                fail = 0;
                sh_acc = 0;
                if (sh_mode == MODE_KEEP) begin
                    keep_pass(n);
                end else begin
                    fail = lpt_pass(n);
                    if (sh_mode == MODE_GREEDY) begin
                        sh_acc = !fail;
                    end else begin
                        sh_acc = !fail && (64'd20 * peak(0, n) < 64'd19 * peak(1, n));
                        if (!sh_acc) keep_pass(n);
                    end
                end
                sh_done = 1;
                sh_rp = 0;
                r.kind = KIND_STATUS;
                r.rebal = sh_acc;
                r.max_load = peak(0, n);
                r.err = fail || sh_ovf;
                pending_results.push_back(r);
            end
            default: begin
                if (sh_done && sh_rp < sh_jobs) begin
                    r.kind = KIND_ASSIGN;
                    r.job_id = sh_ids[sh_rp];
                    r.new_srv = sh_asg[sh_rp];
                    r.old_srv = sh_orig[sh_rp];
                    r.moved = sh_asg[sh_rp] != sh_orig[sh_rp];
                    r.rebal = sh_acc;
                    sh_rp++;
                    if (sh_rp >= sh_jobs) begin
                        r.last = 1;
                        sh_jobs = 0;
                        sh_rp = 0;
                        sh_ovf = 0;
                        sh_done = 0;
                    end
                    pending_results.push_back(r);
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", field, got, want, cycles);
        fails++;
    endtask

    // Result checker: compare every accepted result with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[63:0], 64'd0);
            end else begin
                placement_t w;
                w = pending_results.pop_front();
                if (m_tuser[0] !== w.kind) report_mismatch("kind", m_tuser[0], w.kind);
                if (m_tdata[15:0] !== w.job_id) report_mismatch("job_id", m_tdata[15:0], w.job_id);
                if (m_tdata[19:16] !== w.new_srv)
                    report_mismatch("new_server", m_tdata[19:16], w.new_srv);
                if (m_tdata[23:20] !== w.old_srv)
                    report_mismatch("old_server", m_tdata[23:20], w.old_srv);
                if (m_tdata[24] !== w.moved) report_mismatch("moved", m_tdata[24], w.moved);
                if (m_tdata[25] !== w.rebal) report_mismatch("rebalanced", m_tdata[25], w.rebal);
                if (m_tdata[65:26] !== w.max_load)
                    report_mismatch("max_load", m_tdata[65:26], w.max_load);
                if (m_tdata[66] !== w.err) report_mismatch("error", m_tdata[66], w.err);
                if (m_tlast !== w.last) report_mismatch("last", m_tlast, w.last);
            end
        end
    end

    // Receiver: random back-pressure, or a long counted hold-off when asked
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one transaction and hold it until accepted
    task automatic send_cmd(op_t op, logic [15:0] id = '0, logic [31:0] t = '0,
                            logic [3:0] srv = '0, logic [39:0] total = '0);
        if ($urandom_range(99) < send_idle_pct) begin
            repeat ($urandom_range(4, 1)) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {4'd0, total, srv, t, id};
        do @(posedge aclk); while (!s_tready);
        predict_placement(op, id, t, srv, total);
        items_sent++;
    endtask

    // Hold the input quiet until every result is in and the block settles
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [8:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_MODE:         sh_mode = val[1:0];
            CFG_SERVER_COUNT: sh_count = val[4:0];
            default:          sh_cap = val;
        endcase
    endtask

    task automatic configure(logic [1:0] md, logic [4:0] cnt, logic [8:0] cap);
        drain();
        write_reg(CFG_MODE, md);
        write_reg(CFG_SERVER_COUNT, cnt);
        write_reg(CFG_SERVER_CAPACITY, cap);
    endtask

    function automatic logic [31:0] pick_time();
        case ($urandom_range(5))
            0: return 32'hFFFF_FFFF;
            1: return 32'd0;
            2: return $urandom_range(3);
            3: return $urandom_range(1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [39:0] pick_total();
        case ($urandom_range(3))
            0: return LOAD_MAX;
            1: return {8'd0, $urandom};
            2: return $urandom_range(5000);
            default: return {$urandom[7:0], $urandom};
        endcase
    endfunction

    // Totals, jobs, run, then a full readout plus stray_reads extra reads
    task automatic batch(int jobs, int stray_reads);
        repeat ($urandom_range(4)) send_cmd(OP_LOAD_TOTAL, '0, '0, $urandom, pick_total());
        for (int i = 0; i < jobs; i++) send_cmd(OP_LOAD_JOB, $urandom, pick_time(), $urandom);
        send_cmd(OP_RUN);
        for (int i = 0; i < jobs + stray_reads; i++) send_cmd(OP_READ);
    endtask

    task automatic test_field_extremes();
        configure(MODE_KEEP, 5'd4, 9'd256);
        send_cmd(OP_READ);                                       // read before any run
        send_cmd(OP_LOAD_TOTAL, '0, '0, 4'd0, LOAD_MAX);
        send_cmd(OP_LOAD_TOTAL, '0, '0, 4'd15, '0);
        send_cmd(OP_LOAD_JOB, 16'h0000, 32'h0000_0000, 4'd0);
        send_cmd(OP_LOAD_JOB, 16'hFFFF, 32'hFFFF_FFFF, 4'd15);   // origin past servers in use
        send_cmd(OP_LOAD_JOB, 16'h5A5A, 32'hFFFF_FFFF, 4'd3);
        send_cmd(OP_RUN);
        repeat (4) send_cmd(OP_READ);                            // last one runs past the end
    endtask

    task automatic test_modes();
        configure(MODE_GREEDY, 5'd2, 9'd2);
        send_cmd(OP_LOAD_TOTAL, '0, '0, 4'd1, 40'd100);
        for (int i = 0; i < 5; i++) send_cmd(OP_LOAD_JOB, i, 32'd7, i);   // ties, then no room
        send_cmd(OP_RUN);
        repeat (5) send_cmd(OP_READ);
        configure(2'd3, 5'd31, 9'd0);                            // mode three, count clipped, no room
        batch(20, 1);
        configure(2'd2, 5'd0, 9'd1);                             // adaptive, count zero
        batch(3, 0);
        configure(2'd2, 5'd3, 9'd256);
        send_cmd(OP_LOAD_TOTAL, '0, '0, 4'd0, 40'hFF_FFFF_FFFF);
        for (int i = 0; i < 4; i++) send_cmd(OP_LOAD_JOB, i, 32'd10 + i, 4'd0);
        send_cmd(OP_RUN);
        send_cmd(OP_LOAD_JOB, 16'd9, 32'd1, 4'd2);               // discards the run
        send_cmd(OP_READ);
        send_cmd(OP_RUN);
        repeat (5) send_cmd(OP_READ);
    endtask

    task automatic test_table_overflow();
        configure(MODE_GREEDY, 5'd16, 9'd16);
        for (int i = 0; i < JOB_DEPTH + 2; i++) send_cmd(OP_LOAD_JOB, i, $urandom, $urandom);
        send_cmd(OP_RUN);
        repeat (JOB_DEPTH) send_cmd(OP_READ);
    endtask

    task automatic test_pressure();
        configure(MODE_GREEDY, 5'd5, 9'd8);
        for (int i = 0; i < 12; i++) send_cmd(OP_LOAD_JOB, $urandom, pick_time(), $urandom);
        send_cmd(OP_RUN);
        drain();                                                 // sender waits for the status
        hold_left = 400;
        repeat (12) send_cmd(OP_READ);                           // reads back up behind the hold
        drain();
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 68 : 0;
            recv_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 32 : 0;
            while (items_sent < 600 * (phase + 1)) begin
                if ($urandom_range(3) == 0)
                    configure($urandom, ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 16),
                              ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 8));
                case ($urandom_range(9))
                    0: batch(0, $urandom_range(2));
                    1: batch($urandom_range(30, 48), 0);
                    2: begin
                        send_cmd(op_t'($urandom), $urandom, pick_time(), $urandom, pick_total());
                    end
                    default: batch($urandom_range(1, 16), $urandom_range(1) ? 1 : 0);
                endcase
            end
        end
    endtask

    initial begin
        shadow_reset();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_field_extremes();
        test_modes();
        test_table_overflow();
        test_pressure();
        test_random();
        drain();
        if (fails == 0) begin
            $display("PASS greedy_job_rebalancer_unit");
        end else begin
            $display("FAIL greedy_job_rebalancer_unit");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/grb_pkg.sv
rtl/grb_datapath.sv
rtl/grb_ctrl.sv
rtl/greedy_job_rebalancer_unit.sv
tb/greedy_job_rebalancer_unit_tb.sv
